// ===== rtl/dmbp_pkg.sv =====
// Shared types, codes and tables for the DHCP/BOOTP message byte parser.
// No dependencies.
package dmbp_pkg;

    localparam int DEFAULT_MAX_MESSAGE_BYTES = 576;
    localparam int HEADER_BYTES = 240;
    localparam int NUM_HDR_FIELDS = 15;
    localparam logic [31:0] COOKIE_RESET = 32'h6382_5363;
    localparam logic [7:0] END_CODE_RESET = 8'hFF;

    localparam logic [0:0] CFG_COOKIE = 1'd0;
    localparam logic [0:0] CFG_END_CODE = 1'd1;

    localparam logic [4:0] FC_COOKIE = 5'd14;
    localparam logic [4:0] FC_OPT_ID = 5'd15;
    localparam logic [4:0] FC_OPT_LEN = 5'd16;
    localparam logic [4:0] FC_OPT_DATA = 5'd17;
    localparam logic [4:0] FC_END = 5'd18;
    localparam logic [4:0] FC_DISCARD = 5'd19;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BAD_COOKIE = 3'd1;
    localparam logic [2:0] ST_TRUNCATED = 3'd2;
    localparam logic [2:0] ST_OVERSIZE = 3'd3;
    localparam logic [2:0] ST_AFTER_END = 3'd4;

    localparam logic [7:0] FIELD_START [NUM_HDR_FIELDS] = '{
        8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd8, 8'd10, 8'd12,
        8'd16, 8'd20, 8'd24, 8'd28, 8'd44, 8'd108, 8'd236
    };

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] byte_value;
        logic [7:0] option_length;
        logic [7:0] option_code;
        logic [7:0] field_offset;
        logic [4:0] field_code;
    } result_t;

    function automatic logic [4:0] header_field(input logic [7:0] pos);
        logic [4:0] fc;
        fc = 5'd0;
        for (int k = 1; k < NUM_HDR_FIELDS; k++)
        begin
            if (pos >= FIELD_START[k])
                fc = 5'(k);
        end
        return fc;
    endfunction

endpackage

// ===== rtl/dhcp_message_byte_parser.sv =====
// Top level of the DHCP/BOOTP message byte parser: per-byte tagging, cookie check,
// option walk and a two-entry output buffer. Depends on dmbp_pkg.
//
//  channel  | direction | transaction                  | payload
//  s_axis   | in        | s_tvalid & s_tready          | tdata[7:0] data_byte, tlast last_byte
//  m_axis   | out       | m_tvalid & m_tready          | tdata result (40 bits), tlast message_done
//  cfg      | in        | cfg_we                       | cfg_index, cfg_data
//
// One byte per cycle while s_tready is high; each result is registered in the output
// register, or in the skid register while the output register stalls. Throughput is
// bound only by the output side: s_tready drops only when both registers are full.
// rst_n is asynchronous; it clears parse state and restores register defaults.
// The flagged last byte returns parse state to its post-reset values.
module dhcp_message_byte_parser #(
    parameter int MAX_MESSAGE_BYTES = dmbp_pkg::DEFAULT_MAX_MESSAGE_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // field_code, field_offset, option_code,
                                   // option_length, byte_value, status (low to high)
    output logic        m_tlast,   // message_done
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import dmbp_pkg::*;

    localparam int CNT_W = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_MESSAGE_BYTES);
    localparam logic [CNT_W-1:0] COOKIE_LAST = CNT_W'(HEADER_BYTES - 1);

    typedef enum logic [2:0] {
        PH_HEADER, PH_ID, PH_LEN, PH_DATA, PH_ENDED, PH_ERROR
    } phase_t;

    logic [31:0]      cookie_reg;
    logic [7:0]       end_code_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    phase_t           phase_reg, phase_next;
    logic [7:0]       opt_reg, opt_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       remain_reg, remain_next;
    logic [23:0]      shift_reg, shift_next;

    result_t res;
    result_t main_reg, skid_reg;
    logic    main_last_reg, skid_last_reg;
    logic    main_valid_reg, skid_valid_reg;
    logic    accept;
    logic [7:0] b;
    logic [4:0] hfc;
    logic [7:0] remain_dec;

    assign b = s_tdata;
    assign accept = s_tvalid && s_tready;
    assign hfc = header_field(cnt_reg[7:0]);
    assign remain_dec = remain_reg - 8'd1;

    always_comb
    begin
        res = '0;
        res.field_code = FC_DISCARD;
        res.byte_value = b;
        res.status = ST_OK;
        phase_next = phase_reg;
        opt_next = opt_reg;
        len_next = len_reg;
        remain_next = remain_reg;
        shift_next = shift_reg;
        cnt_next = (cnt_reg < MAX_CNT) ? cnt_reg + CNT_W'(1) : cnt_reg;

        if (phase_reg == PH_ENDED || phase_reg == PH_ERROR)
        begin
            res.status = ST_AFTER_END;
        end
        else if (cnt_reg >= MAX_CNT)
        begin
            res.status = ST_OVERSIZE;
            phase_next = PH_ERROR;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    res.field_code = hfc;
                    res.field_offset = cnt_reg[7:0] - FIELD_START[hfc[3:0]];
                    if (hfc == FC_COOKIE)
                    begin
                        shift_next = {shift_reg[15:0], b};
                        if (cnt_reg == COOKIE_LAST)
                        begin
                            if ({shift_reg, b} != cookie_reg)
                            begin
                                res.status = ST_BAD_COOKIE;
                                phase_next = PH_ERROR;
                            end
                            else
                                phase_next = PH_ID;
                        end
                    end
                end
                PH_ID:
                begin
                    res.option_code = b;
                    if (b == end_code_reg)
                    begin
                        res.field_code = FC_END;
                        phase_next = PH_ENDED;
                    end
                    else
                    begin
                        res.field_code = FC_OPT_ID;
                        opt_next = b;
                        len_next = 8'd0;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    res.field_code = FC_OPT_LEN;
                    res.option_code = opt_reg;
                    res.option_length = b;
                    len_next = b;
                    remain_next = b;
                    phase_next = (b == 8'd0) ? PH_ID : PH_DATA;
                end
                default:
                begin
                    res.field_code = FC_OPT_DATA;
                    res.option_code = opt_reg;
                    res.option_length = len_reg;
                    res.field_offset = len_reg - remain_reg;
                    remain_next = remain_dec;
                    if (remain_dec == 8'd0)
                        phase_next = PH_ID;
                end
            endcase
        end

        if (s_tlast && res.status == ST_OK && phase_next != PH_ENDED)
            res.status = ST_TRUNCATED;

        if (s_tlast)
        begin
            cnt_next = '0;
            phase_next = PH_HEADER;
            opt_next = 8'd0;
            len_next = 8'd0;
            remain_next = 8'd0;
            shift_next = 24'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cookie_reg <= COOKIE_RESET;
            end_code_reg <= END_CODE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COOKIE:   cookie_reg <= cfg_data;
                CFG_END_CODE: end_code_reg <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            phase_reg <= PH_HEADER;
            opt_reg <= 8'd0;
            len_reg <= 8'd0;
            remain_reg <= 8'd0;
            shift_reg <= 24'd0;
        end
        else if (accept)
        begin
            cnt_reg <= cnt_next;
            phase_reg <= phase_next;
            opt_reg <= opt_next;
            len_reg <= len_next;
            remain_reg <= remain_next;
            shift_reg <= shift_next;
        end
    end

    // output register plus skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                main_valid_reg <= accept;
        end
        else if (accept)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
                main_last_reg <= skid_last_reg;
            end
            else if (accept)
            begin
                main_reg <= res;
                main_last_reg <= s_tlast;
            end
        end
        else if (accept)
        begin
            skid_reg <= res;
            skid_last_reg <= s_tlast;
        end
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = main_valid_reg;
    assign m_tdata = main_reg;
    assign m_tlast = main_last_reg;

    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held while output register empty");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> cnt_reg == '0 && phase_reg == PH_HEADER)
        else $error("parse state not cleared after last byte");

    a_data_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> remain_reg != 8'd0)
        else $error("option data phase with nothing remaining");

    a_header_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> cnt_reg < CNT_W'(HEADER_BYTES))
        else $error("header phase past the cookie");

endmodule
